FILE: rtl/core/lsbb64_pkg.sv
// Shared types, constants and the Base64 alphabet lookup for the extractor.
`timescale 1ns / 1ps

package lsbb64_pkg;

	// Length of the hidden character-count header, in carrier bits.
	localparam int HEADER_BITS = 32;
	localparam int HDR_CNT_W   = $clog2(HEADER_BITS + 1);
	localparam int CHARS_W     = HEADER_BITS - 1;

	// Base64 padding character.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Decoder bit balance after a reset or a new message (minus eight).
	localparam logic [3:0] PEND_INIT = 4'b1000;

	// One carrier word.
	typedef struct packed {
		logic [7:0] carrier_byte;
		logic       message_start;
	} carrier_word_t;

	// One result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       message_end;
	} result_word_t;

	// Outcome of one processed carrier word.
	typedef struct packed {
		logic         has_result;
		result_word_t word;
	} step_res_t;

	// Maps a character to its sextet; bit 6 is set when the character is in the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		priority if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/lsbb64_in_reg.sv
// Input register stage that holds one carrier word for the extraction logic.
`timescale 1ns / 1ps

module lsbb64_in_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     carrier_valid,
	output logic                     carrier_stall,
	input  lsbb64_pkg::carrier_word_t carrier_word,
	input  logic                     down_free,
	output logic                     go,
	output lsbb64_pkg::carrier_word_t word_s1
);

	logic valid_s1;

	// The held word moves on whenever the result register can take its outcome.
	assign go            = valid_s1 && down_free;
	assign carrier_stall = valid_s1 && !down_free;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!carrier_stall) begin
			valid_s1 <= carrier_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (carrier_valid && !carrier_stall) begin
			word_s1 <= carrier_word;
		end
	end

endmodule

FILE: rtl/core/lsbb64_extract.sv
// Message state, header and character assembly, and the streaming Base64 decoder.
`timescale 1ns / 1ps

module lsbb64_extract (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  lsbb64_pkg::carrier_word_t word_s1,
	output lsbb64_pkg::step_res_t     res
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [1:0]                        phase_q;
	logic [lsbb64_pkg::HEADER_BITS-1:0] hdr_shift_q;
	logic [lsbb64_pkg::HDR_CNT_W-1:0]   hdr_cnt_q;
	logic [lsbb64_pkg::CHARS_W-1:0]     chars_q;
	logic [7:0]                        char_q;
	logic [2:0]                        char_cnt_q;
	logic [11:0]                       acc_q;
	logic [3:0]                        pend_q;
	logic                              pad_q;

	logic [1:0]                        phase_d;
	logic [lsbb64_pkg::HEADER_BITS-1:0] hdr_shift_d;
	logic [lsbb64_pkg::HDR_CNT_W-1:0]   hdr_cnt_d;
	logic [lsbb64_pkg::CHARS_W-1:0]     chars_d;
	logic [7:0]                        char_d;
	logic [2:0]                        char_cnt_d;
	logic [11:0]                       acc_d;
	logic [3:0]                        pend_d;
	logic                              pad_d;

	// Next state and the result for the held carrier word.
	always_comb begin
		logic       bit_in;
		logic [7:0] ch;
		logic [6:0] sx;
		logic [7:0] byte_v;
		logic       vld;
		logic       endf;

		bit_in      = word_s1.carrier_byte[0];
		ch          = '0;
		sx          = '0;
		byte_v      = '0;
		vld         = 1'b0;
		endf        = 1'b0;
		phase_d     = phase_q;
		hdr_shift_d = hdr_shift_q;
		hdr_cnt_d   = hdr_cnt_q;
		chars_d     = chars_q;
		char_d      = char_q;
		char_cnt_d  = char_cnt_q;
		acc_d       = acc_q;
		pend_d      = pend_q;
		pad_d       = pad_q;

		// A start mark clears the message and makes this word the first header bit.
		if (word_s1.message_start) begin
			phase_d     = PH_HEADER;
			hdr_shift_d = '0;
			hdr_cnt_d   = '0;
			chars_d     = '0;
			char_d      = '0;
			char_cnt_d  = '0;
			acc_d       = '0;
			pend_d      = lsbb64_pkg::PEND_INIT;
			pad_d       = 1'b0;
		end

		unique case (phase_d)
			PH_HEADER: begin
				hdr_shift_d = {hdr_shift_d[lsbb64_pkg::HEADER_BITS-2:0], bit_in};
				hdr_cnt_d   = hdr_cnt_d + lsbb64_pkg::HDR_CNT_W'(1);
				if (hdr_cnt_d == lsbb64_pkg::HDR_CNT_W'(lsbb64_pkg::HEADER_BITS)) begin
					// A count with its top bit set counts as zero.
					if (hdr_shift_d[lsbb64_pkg::HEADER_BITS-1]) begin
						chars_d = '0;
					end else begin
						chars_d = hdr_shift_d[lsbb64_pkg::CHARS_W-1:0];
					end
					if (chars_d == '0) begin
						phase_d = PH_DONE;
						endf    = 1'b1;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				ch = {char_d[6:0], bit_in};
				if (char_cnt_d == 3'd7) begin
					char_cnt_d = '0;
					char_d     = '0;
					// Feed the finished character to the Base64 decoder.
					if (!pad_d) begin
						sx = lsbb64_pkg::sextet_of(ch);
						if (sx[6]) begin
							acc_d  = {acc_d[5:0], sx[5:0]};
							pend_d = pend_d + 4'd6;
							if (!pend_d[3]) begin
								byte_v = 8'(acc_d >> pend_d[2:0]);
								pend_d = pend_d - 4'd8;
								vld    = 1'b1;
							end
						end else if (ch == lsbb64_pkg::PAD_CHAR) begin
							pad_d = 1'b1;
						end
					end
					chars_d = chars_d - lsbb64_pkg::CHARS_W'(1);
					if (chars_d == '0) begin
						phase_d = PH_DONE;
						endf    = 1'b1;
					end
				end else begin
					char_cnt_d = char_cnt_d + 3'd1;
					char_d     = ch;
				end
			end
			PH_IDLE, PH_DONE: begin
				// Words outside a message are dropped.
			end
			default: begin
			end
		endcase

		res.has_result       = vld || endf;
		res.word.out_byte    = vld ? byte_v : 8'd0;
		res.word.byte_valid  = vld;
		res.word.message_end = endf;
	end

	// State registers advance once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_shift_q <= '0;
			hdr_cnt_q   <= '0;
			chars_q     <= '0;
			char_q      <= '0;
			char_cnt_q  <= '0;
			acc_q       <= '0;
			pend_q      <= lsbb64_pkg::PEND_INIT;
			pad_q       <= 1'b0;
		end else if (go) begin
			phase_q     <= phase_d;
			hdr_shift_q <= hdr_shift_d;
			hdr_cnt_q   <= hdr_cnt_d;
			chars_q     <= chars_d;
			char_q      <= char_d;
			char_cnt_q  <= char_cnt_d;
			acc_q       <= acc_d;
			pend_q      <= pend_d;
			pad_q       <= pad_d;
		end
	end

`ifndef SYNTHESIS
	// The decoder balance stays between minus eight and minus one between words.
	a_pend_negative: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q[3])
		else $error("decoder bit balance left its range");

	// A message body always has characters left to receive.
	a_body_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (chars_q != '0))
		else $error("body phase with no characters left");

	// The header count never reaches the header length while still in the header.
	a_hdr_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |->
		(hdr_cnt_q < lsbb64_pkg::HDR_CNT_W'(lsbb64_pkg::HEADER_BITS)))
		else $error("header bit count overran");

	// Ending a message leaves the block done.
	a_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.word.message_end) |=> (phase_q == PH_DONE))
		else $error("message end without done phase");
`endif

endmodule

FILE: rtl/core/lsbb64_out_reg.sv
// Result register that holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module lsbb64_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  lsbb64_pkg::step_res_t    res,
	output logic                     down_free,
	output logic                     result_valid,
	input  logic                     result_stall,
	output lsbb64_pkg::result_word_t result_word
);

	logic valid_q;

	// The register can load when it is empty or its word leaves this cycle.
	assign down_free    = !valid_q || !result_stall;
	assign result_valid = valid_q;

	// Valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (down_free) begin
			valid_q <= go && res.has_result;
		end
	end

	// Payload of the result register.
	always_ff @(posedge clk) begin
		if (go && res.has_result && down_free) begin
			result_word <= res.word;
		end
	end

endmodule

FILE: rtl/core/lsb_stego_base64_extractor_core.sv
// Top level of the LSB steganography extractor with streaming Base64 decoder.
//
//   channel   valid           stall           word
//   carrier   carrier_valid   carrier_stall   carrier_word (carrier_byte, message_start)
//   result    result_valid    result_stall    result_word (out_byte, byte_valid, message_end)
//
// One carrier word is taken per cycle unless stalled; results wait in the result register.
// The input register and the result register bound a single pass of decode logic.
// A result register stall backs up into the input register and then into carrier_stall.
// Words that cause no result leave nothing in the result register but still wait for down_free.
// Reset (arst_n low) empties both registers and returns the block to idle.
`timescale 1ns / 1ps

module lsb_stego_base64_extractor_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     carrier_valid,
	output logic                     carrier_stall,
	input  lsbb64_pkg::carrier_word_t carrier_word,
	output logic                     result_valid,
	input  logic                     result_stall,
	output lsbb64_pkg::result_word_t result_word
);

	logic                      down_free;
	logic                      go;
	lsbb64_pkg::carrier_word_t word_s1;
	lsbb64_pkg::step_res_t     res;

	// Input register.
	lsbb64_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.carrier_valid (carrier_valid),
		.carrier_stall (carrier_stall),
		.carrier_word  (carrier_word),
		.down_free     (down_free),
		.go            (go),
		.word_s1       (word_s1)
	);

	// Message state and decoding.
	lsbb64_extract u_extract (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.word_s1 (word_s1),
		.res     (res)
	);

	// Result register.
	lsbb64_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.res          (res),
		.down_free    (down_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule
